// File: rtl/ples_pkg.sv
package ples_pkg;

	// Lanes that are actually built; the ports always carry eight
	localparam int MAX_LANES = 8;
	localparam int LANES = 8;
	localparam logic [MAX_LANES-1:0] LANE_LIMIT = MAX_LANES'((1 << LANES) - 1);

	localparam int BYTE_BITS = 8;
	localparam int COLOR_W = 24;
	localparam int HOLD_W = 16;
	localparam int BIT_IDX_W = $clog2(BYTE_BITS);

	// Byte selector codes
	localparam logic [1:0] SEL_GREEN = 2'd0;
	localparam logic [1:0] SEL_RED = 2'd1;
	localparam logic [1:0] SEL_BLUE = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_LANE_MASK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DATA = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL = 3'd3;

	localparam logic [MAX_LANES-1:0] RST_LANE_MASK = 8'hFF;
	localparam logic [HOLD_W-1:0] RST_LEAD = 16'd18;
	localparam logic [HOLD_W-1:0] RST_DATA = 16'd43;
	localparam logic [HOLD_W-1:0] RST_TAIL = 16'd62;

	typedef enum logic [1:0] {
		PH_LEAD = 2'd0,
		PH_DATA = 2'd1,
		PH_TAIL = 2'd2
	} phase_t;

	typedef struct packed {
		logic [COLOR_W-1:0] lane0_color;
		logic [COLOR_W-1:0] lane1_color;
		logic [COLOR_W-1:0] lane2_color;
		logic [COLOR_W-1:0] lane3_color;
		logic [COLOR_W-1:0] lane4_color;
		logic [COLOR_W-1:0] lane5_color;
		logic [COLOR_W-1:0] lane6_color;
		logic [COLOR_W-1:0] lane7_color;
		logic [1:0] byte_sel;
	} in_item_t;

	typedef struct packed {
		logic [MAX_LANES-1:0] pins;
		logic [HOLD_W-1:0] hold_cycles;
		logic [1:0] phase;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [MAX_LANES-1:0] lane_mask;
		logic [HOLD_W-1:0] lead_cycles;
		logic [HOLD_W-1:0] data_cycles;
		logic [HOLD_W-1:0] tail_cycles;
	} cfg_t;

	// Sequencer position handed to the merge stage
	typedef struct packed {
		phase_t phase;
		logic last;
	} seq_t;

	// Lane register controls
	typedef struct packed {
		logic load;
		logic shift;
	} lane_ctl_t;

endpackage

// File: rtl/ples_lane.sv
module ples_lane (
	input logic clk,
	input logic [ples_pkg::COLOR_W-1:0] color,
	input logic [1:0] byte_sel,
	input ples_pkg::lane_ctl_t ctl,
	output logic bit_out
);

	logic [ples_pkg::BYTE_BITS-1:0] byte_q;
	logic [ples_pkg::BYTE_BITS-1:0] picked;

	always_comb begin
		unique case (byte_sel)
			ples_pkg::SEL_GREEN: picked = color[15:8];
			ples_pkg::SEL_RED: picked = color[23:16];
			ples_pkg::SEL_BLUE: picked = color[7:0];
			default: picked = '0;
		endcase
	end

	// Load on a new item, else advance MSB first after each tail beat
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			byte_q <= picked;
		end else if (ctl.shift) begin
			byte_q <= {byte_q[ples_pkg::BYTE_BITS-2:0], 1'b0};
		end
	end

	assign bit_out = byte_q[ples_pkg::BYTE_BITS-1];

endmodule

// File: rtl/ples_merge.sv
module ples_merge (
	input logic [ples_pkg::MAX_LANES-1:0] lane_bits,
	input ples_pkg::cfg_t cfg,
	input ples_pkg::seq_t seq,
	output ples_pkg::out_item_t result
);

	logic [ples_pkg::MAX_LANES-1:0] enabled;
	logic [ples_pkg::HOLD_W-1:0] hold_raw;

	assign enabled = cfg.lane_mask & ples_pkg::LANE_LIMIT;

	always_comb begin
		result = '0;
		hold_raw = cfg.lead_cycles;
		unique case (seq.phase)
			ples_pkg::PH_LEAD: begin
				result.pins = enabled;
				hold_raw = cfg.lead_cycles;
			end
			ples_pkg::PH_DATA: begin
				result.pins = lane_bits & enabled;
				hold_raw = cfg.data_cycles;
			end
			ples_pkg::PH_TAIL: begin
				result.pins = '0;
				hold_raw = cfg.tail_cycles;
			end
			default: begin
				result.pins = '0;
				hold_raw = cfg.lead_cycles;
			end
		endcase
		// a zero hold value is raised to one
		result.hold_cycles = (hold_raw == '0) ? ples_pkg::HOLD_W'(1) : hold_raw;
		result.phase = seq.phase;
		result.last = seq.last;
	end

endmodule

// File: rtl/parallel_led_strand_bit_encoder.sv
// Start is taken while not busy; the sequencer then goes active, the merge
// forms each phase beat combinationally and the output register puts it on
// result with strobe. Throughput: 24 phase beats per item, one per cycle,
// set by three phases for each of the eight bits; a new item is taken in the
// cycle the previous item's final tail beat is registered, with no gap.
// Reset: sequencer idle, no strobe, lane mask and timing registers at their
// defaults. The receiver cannot stall; every beat stands for exactly one cycle.
module parallel_led_strand_bit_encoder (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input ples_pkg::in_item_t item,
	output logic strobe,
	output ples_pkg::out_item_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [ples_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ples_pkg::HOLD_W-1:0] cfg_data
);

	ples_pkg::cfg_t cfg_q;
	logic active_q;
	logic [ples_pkg::BIT_IDX_W-1:0] bit_q;
	ples_pkg::phase_t phase_q;
	logic strobe_q;
	ples_pkg::out_item_t result_q;

	logic accept;
	logic final_beat;
	ples_pkg::lane_ctl_t lane_ctl;
	ples_pkg::seq_t seq;
	ples_pkg::out_item_t merged;
	logic [ples_pkg::MAX_LANES-1:0] lane_bits;
	logic [ples_pkg::COLOR_W-1:0] colors [ples_pkg::MAX_LANES];

	// Take configuration only while idle and no item is being offered, so a
	// write never lands inside an item or at the edge that takes one
	assign cfg_ready = !active_q && !start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lane_mask <= ples_pkg::RST_LANE_MASK;
			cfg_q.lead_cycles <= ples_pkg::RST_LEAD;
			cfg_q.data_cycles <= ples_pkg::RST_DATA;
			cfg_q.tail_cycles <= ples_pkg::RST_TAIL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ples_pkg::REG_LANE_MASK:
					cfg_q.lane_mask <= cfg_data[ples_pkg::MAX_LANES-1:0];
				ples_pkg::REG_LEAD: cfg_q.lead_cycles <= cfg_data;
				ples_pkg::REG_DATA: cfg_q.data_cycles <= cfg_data;
				ples_pkg::REG_TAIL: cfg_q.tail_cycles <= cfg_data;
				default: ;
			endcase
		end
	end

	// The final tail beat of the eighth bit frees the lanes this cycle
	assign final_beat = active_q && (phase_q == ples_pkg::PH_TAIL)
		&& (bit_q == ples_pkg::BIT_IDX_W'(ples_pkg::BYTE_BITS - 1));
	assign busy = active_q && !final_beat;
	assign accept = start && !busy;

	assign lane_ctl.load = accept;
	assign lane_ctl.shift = active_q && (phase_q == ples_pkg::PH_TAIL);

	assign seq.phase = phase_q;
	assign seq.last = final_beat;

	assign colors[0] = item.lane0_color;
	assign colors[1] = item.lane1_color;
	assign colors[2] = item.lane2_color;
	assign colors[3] = item.lane3_color;
	assign colors[4] = item.lane4_color;
	assign colors[5] = item.lane5_color;
	assign colors[6] = item.lane6_color;
	assign colors[7] = item.lane7_color;

	// One lane per built strand; strands past LANES stay low
	for (genvar k = 0; k < ples_pkg::MAX_LANES; k++) begin : g_lane
		if (k < ples_pkg::LANES) begin : g_on
			ples_lane u_lane (
				.clk(clk),
				.color(colors[k]),
				.byte_sel(item.byte_sel),
				.ctl(lane_ctl),
				.bit_out(lane_bits[k])
			);
		end else begin : g_off
			assign lane_bits[k] = 1'b0;
		end
	end

	ples_merge u_merge (
		.lane_bits(lane_bits),
		.cfg(cfg_q),
		.seq(seq),
		.result(merged)
	);

	// Sequencer: lead, data, tail for each of the eight bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			bit_q <= '0;
			phase_q <= ples_pkg::PH_LEAD;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (accept) begin
				active_q <= 1'b1;
				bit_q <= '0;
				phase_q <= ples_pkg::PH_LEAD;
			end else if (active_q) begin
				unique case (phase_q)
					ples_pkg::PH_LEAD: phase_q <= ples_pkg::PH_DATA;
					ples_pkg::PH_DATA: phase_q <= ples_pkg::PH_TAIL;
					default: begin
						phase_q <= ples_pkg::PH_LEAD;
						bit_q <= bit_q + 1'b1;
						if (final_beat) begin
							active_q <= 1'b0;
						end
					end
				endcase
			end
		end
	end

	// Register each beat in the output register while the sequencer is active
	always_ff @(posedge clk) begin
		if (active_q) begin
			result_q <= merged;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> active_q && phase_q == ples_pkg::PH_LEAD && bit_q == '0)
		else $error("accepted item did not start at the first lead phase");

	a_beat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |=> strobe_q)
		else $error("active phase produced no beat");

	a_last_tail: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.last |-> result_q.phase == ples_pkg::PH_TAIL
			&& result_q.pins == '0)
		else $error("last beat is not a low tail");

	a_data_masked: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.phase == ples_pkg::PH_DATA
			|-> (result_q.pins & ~(cfg_q.lane_mask & ples_pkg::LANE_LIMIT)) == '0)
		else $error("data beat drives a disabled lane");

	a_hold_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> result_q.hold_cycles != '0)
		else $error("beat with zero hold time");

endmodule
